FILE: rtl/sdsr_pkg.sv
// constants and codes for the sd card spi reset and block read sequencer
package sdsr_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned IDLE_BYTES  = 15;

  localparam int unsigned CNT_W   = 10;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned PADDR_W = 3;

  // actions
  localparam logic [1:0] ACT_RESET     = 2'd0;
  localparam logic [1:0] ACT_SECT_READ = 2'd1;
  localparam logic [1:0] ACT_BYTE_READ = 2'd2;
  localparam logic [1:0] ACT_RX        = 2'd3;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_WAKE  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_PRE   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_BODY  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_POLL  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_TOKEN = 4'd5;
  localparam logic [PHASE_W-1:0] PH_DATA  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_CRC   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_TRAIL = 4'd8;

  // command in flight
  typedef enum logic [1:0] {
    CM_RESET0    = 2'd0,
    CM_LEN_FINAL = 2'd1,
    CM_LEN_SET   = 2'd2,
    CM_READ      = 2'd3
  } cmd_e;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_RESET_FAIL = 2'd1;
  localparam logic [1:0] ST_READ_FAIL  = 2'd2;

  // register indexes
  localparam logic [PADDR_W-3:0] REG_TRY_LIMIT = '0;

  localparam logic [7:0] TRY_LIMIT_RESET = 8'd200;

  localparam logic [7:0] CMD_START  = 8'h40;
  localparam logic [7:0] CMD0_CRC   = 8'h95;
  localparam logic [7:0] DATA_TOKEN = 8'hfe;
  localparam logic [7:0] FILL_BYTE  = 8'hff;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] CMD_NUM_0  = 8'd0;
  localparam logic [7:0] CMD_NUM_16 = 8'd16;
  localparam logic [7:0] CMD_NUM_17 = 8'd17;

  localparam logic [CNT_W-1:0] PRE_BYTES  = 10'd3;
  localparam logic [CNT_W-1:0] BODY_BYTES = 10'd6;
  localparam logic [CNT_W-1:0] CRC_BYTES  = 10'd2;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       transfer;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

FILE: rtl/sd_spi_reset_and_block_read_core.sv
// sd card spi-mode sequencer: cmd0 reset, cmd16 block length, cmd17 block and byte reads
//
// Each input beat is one step of the sequencer and yields exactly one result beat: either
// a request for one SPI byte exchange (tx_byte_o, chip_select_o, transfer_o), a done
// report with status_o, or, when idle, only the chip_select_o level. Start a reset,
// sector read or byte read with action 0, 1 or 2; hand each received byte back with
// action 3, which also advances the sequence. The beat goes from the input register
// through the step logic into the output register, so a new beat is taken every clock
// while results are drained, and the input register holds one more beat on an output stall.
// try_limit (APB address 0) bounds reply polls per command and command retries.
module sd_spi_reset_and_block_read_core
  import sdsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [31:0]        address_i,
  input  logic [9:0]         length_i,
  input  logic [7:0]         rx_byte_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         tx_byte_o,
  output logic               chip_select_o,
  output logic               transfer_o,
  output logic [7:0]         data_byte_o,
  output logic               data_valid_o,
  output logic               done_res_o,
  output logic [1:0]         status_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration
  logic [7:0] try_limit_q;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_TRY_LIMIT);
  assign prdata  = reg_sel ? {24'd0, try_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      try_limit_q <= TRY_LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      try_limit_q <= pwdata[7:0];
    end
  end

  // input register
  logic        inv_q;
  logic [1:0]  act_q;
  logic [31:0] addr_in_q;
  logic [9:0]  len_in_q;
  logic [7:0]  rx_q;
  logic        outv_q;
  logic        adv;

  assign adv        = inv_q && (!outv_q || !out_stall_i);
  assign in_stall_o = inv_q && outv_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (!in_stall_o) begin
      inv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      act_q     <= action_i;
      addr_in_q <= address_i;
      len_in_q  <= length_i;
      rx_q      <= rx_byte_i;
    end
  end

  // sequencer state
  logic [PHASE_W-1:0] ph_q, ph_d;
  logic [1:0]         mode_q, mode_d;
  logic [CNT_W-1:0]   bc_q, bc_d;
  logic [7:0]         pc_q, pc_d;
  logic [7:0]         rc_q, rc_d;
  logic [31:0]        addr_q, addr_d;
  logic [CNT_W-1:0]   len_q, len_d;
  cmd_e               cmd_q, cmd_d;
  logic               rfail_q, rfail_d;
  logic               cs_lvl_q, cs_lvl_d;

  res_t res_d, res_q;

  logic [CNT_W:0]   bc_inc;
  logic [7:0]       pc_inc;
  logic [7:0]       rc_inc;
  logic [CNT_W:0]   total;
  logic [7:0]       expect_b;
  logic [31:0]      sect_arg;
  logic [31:0]      arg;
  logic [7:0]       cmd_num;
  logic             idle_step;
  logic             fin;
  logic [1:0]       fin_code;
  logic             matched;
  logic             cmd_over;

  assign bc_inc   = {1'b0, bc_q} + 1'b1;
  assign pc_inc   = (pc_q == 8'hff) ? pc_q : pc_q + 8'd1;
  assign rc_inc   = (rc_q == 8'hff) ? rc_q : rc_q + 8'd1;
  assign total    = (mode_q == ACT_BYTE_READ) ? {1'b0, len_q} : (CNT_W+1)'(BLOCK_BYTES);
  assign expect_b = (cmd_q == CM_RESET0) ? R1_IDLE : R1_READY;
  assign matched  = (rx_q == expect_b);
  assign cmd_over = matched || (pc_inc >= try_limit_q);

  always_comb begin
    ph_d      = ph_q;
    mode_d    = mode_q;
    bc_d      = bc_q;
    pc_d      = pc_q;
    rc_d      = rc_q;
    addr_d    = addr_q;
    len_d     = len_q;
    cmd_d     = cmd_q;
    rfail_d   = rfail_q;
    cs_lvl_d  = cs_lvl_q;
    idle_step = 1'b0;
    fin       = 1'b0;
    fin_code  = ST_OK;
    res_d     = '0;

    unique case (act_q)
      ACT_RESET: begin
        mode_d  = ACT_RESET;
        rfail_d = 1'b0;
        rc_d    = '0;
        ph_d    = PH_WAKE;
        bc_d    = '0;
      end
      ACT_SECT_READ, ACT_BYTE_READ: begin
        mode_d = act_q;
        addr_d = addr_in_q;
        rc_d   = '0;
        ph_d   = PH_PRE;
        bc_d   = '0;
        pc_d   = '0;
        if (act_q == ACT_BYTE_READ) begin
          len_d = len_in_q;
          cmd_d = CM_LEN_SET;
        end else begin
          cmd_d = CM_READ;
        end
      end
      default: begin
        unique case (ph_q)
          PH_IDLE: begin
            idle_step = 1'b1;
          end
          PH_WAKE: begin
            bc_d = bc_inc[CNT_W-1:0];
            if (bc_inc >= (CNT_W+1)'(IDLE_BYTES)) begin
              rc_d  = '0;
              cmd_d = CM_RESET0;
              ph_d  = PH_PRE;
              bc_d  = '0;
              pc_d  = '0;
            end
          end
          PH_PRE: begin
            bc_d = bc_inc[CNT_W-1:0];
            if (bc_inc >= {1'b0, PRE_BYTES}) begin
              ph_d = PH_BODY;
              bc_d = '0;
            end
          end
          PH_BODY: begin
            bc_d = bc_inc[CNT_W-1:0];
            if (bc_inc >= {1'b0, BODY_BYTES}) begin
              ph_d = PH_POLL;
              pc_d = '0;
            end
          end
          PH_POLL: begin
            pc_d = pc_inc;
            if (cmd_over) begin
              unique case (cmd_q)
                CM_RESET0: begin
                  rc_d = rc_inc;
                  if (matched) begin
                    rfail_d = 1'b0;
                    ph_d    = PH_TRAIL;
                  end else if (rc_inc >= try_limit_q) begin
                    rfail_d = 1'b1;
                    ph_d    = PH_TRAIL;
                  end else begin
                    ph_d = PH_PRE;
                    bc_d = '0;
                    pc_d = '0;
                  end
                end
                CM_LEN_FINAL: begin
                  fin = 1'b1;
                end
                CM_LEN_SET: begin
                  rc_d  = '0;
                  cmd_d = CM_READ;
                  ph_d  = PH_PRE;
                  bc_d  = '0;
                  pc_d  = '0;
                end
                default: begin
                  rc_d = rc_inc;
                  if (matched) begin
                    ph_d = PH_TOKEN;
                  end else if (rc_inc >= try_limit_q) begin
                    fin      = 1'b1;
                    fin_code = ST_READ_FAIL;
                  end else begin
                    ph_d = PH_PRE;
                    bc_d = '0;
                    pc_d = '0;
                  end
                end
              endcase
            end
          end
          PH_TOKEN: begin
            if (rx_q == DATA_TOKEN) begin
              bc_d = '0;
              ph_d = (total == '0) ? PH_CRC : PH_DATA;
            end
          end
          PH_DATA: begin
            res_d.data_byte  = rx_q;
            res_d.data_valid = 1'b1;
            bc_d             = bc_inc[CNT_W-1:0];
            if (bc_inc >= total) begin
              ph_d = PH_CRC;
              bc_d = '0;
            end
          end
          PH_CRC: begin
            bc_d = bc_inc[CNT_W-1:0];
            if (bc_inc >= {1'b0, CRC_BYTES}) begin
              ph_d = PH_TRAIL;
            end
          end
          default: begin
            if ((mode_q == ACT_RESET && !rfail_q) || mode_q == ACT_BYTE_READ) begin
              cmd_d = CM_LEN_FINAL;
              ph_d  = PH_PRE;
              bc_d  = '0;
              pc_d  = '0;
            end else begin
              fin      = 1'b1;
              fin_code = (mode_q == ACT_RESET) ? ST_RESET_FAIL : ST_OK;
            end
          end
        endcase
      end
    endcase

    if (fin) begin
      ph_d     = PH_IDLE;
      cs_lvl_d = 1'b0;
    end

    // command framing from the next state
    sect_arg = addr_d * 32'(BLOCK_BYTES);
    unique case (cmd_d)
      CM_RESET0:    arg = 32'd0;
      CM_LEN_FINAL: arg = 32'(BLOCK_BYTES);
      CM_LEN_SET:   arg = {22'd0, len_d};
      default:      arg = (mode_d == ACT_SECT_READ) ? sect_arg : addr_d;
    endcase
    unique case (cmd_d)
      CM_RESET0: cmd_num = CMD_NUM_0;
      CM_READ:   cmd_num = CMD_NUM_17;
      default:   cmd_num = CMD_NUM_16;
    endcase

    if (idle_step) begin
      res_d.chip_select = cs_lvl_q;
    end else if (fin) begin
      res_d.done_res = 1'b1;
      res_d.status   = fin_code;
    end else begin
      res_d.transfer = 1'b1;
      res_d.tx_byte  = FILL_BYTE;
      if (ph_d == PH_WAKE || ph_d == PH_PRE) begin
        res_d.chip_select = 1'b1;
      end else if (ph_d == PH_BODY) begin
        priority case (bc_d)
          10'd0:   res_d.tx_byte = CMD_START | cmd_num;
          10'd1:   res_d.tx_byte = arg[31:24];
          10'd2:   res_d.tx_byte = arg[23:16];
          10'd3:   res_d.tx_byte = arg[15:8];
          10'd4:   res_d.tx_byte = arg[7:0];
          default: res_d.tx_byte = (cmd_d == CM_RESET0) ? CMD0_CRC : FILL_BYTE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      mode_q   <= ACT_RESET;
      bc_q     <= '0;
      pc_q     <= '0;
      rc_q     <= '0;
      addr_q   <= '0;
      len_q    <= CNT_W'(BLOCK_BYTES);
      cmd_q    <= CM_RESET0;
      rfail_q  <= 1'b0;
      cs_lvl_q <= 1'b1;
    end else if (adv) begin
      ph_q     <= ph_d;
      mode_q   <= mode_d;
      bc_q     <= bc_d;
      pc_q     <= pc_d;
      rc_q     <= rc_d;
      addr_q   <= addr_d;
      len_q    <= len_d;
      cmd_q    <= cmd_d;
      rfail_q  <= rfail_d;
      cs_lvl_q <= cs_lvl_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (adv) begin
      outv_q <= 1'b1;
    end else if (!out_stall_i) begin
      outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = outv_q;
  assign tx_byte_o     = res_q.tx_byte;
  assign chip_select_o = res_q.chip_select;
  assign transfer_o    = res_q.transfer;
  assign data_byte_o   = res_q.data_byte;
  assign data_valid_o  = res_q.data_valid;
  assign done_res_o    = res_q.done_res;
  assign status_o      = res_q.status;

endmodule

FILE: tb/sd_spi_reset_and_block_read_core_tb.sv
// testbench for the sd card spi sequencer: scripted card replies, step prediction, beat checks
module sd_spi_reset_and_block_read_core_tb
  import sdsr_pkg::*;
;

  localparam int STUCK_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [9:0]  length;
    logic [7:0]  rx;
  } host_req_t;

  typedef struct packed {
    logic [PHASE_W-1:0] ph;
    logic [1:0]         mode;
    logic [CNT_W-1:0]   cnt;
    logic [7:0]         polls;
    logic [7:0]         tries;
    logic [31:0]        addr;
    logic [CNT_W-1:0]   len;
    cmd_e               cmd;
    logic               rst_fail;
    logic               idle_cs;
    logic [7:0]         try_limit;
  } seq_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         action_i;
  logic [31:0]        address_i;
  logic [9:0]         length_i;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         tx_byte_o;
  logic               chip_select_o;
  logic               transfer_o;
  logic [7:0]         data_byte_o;
  logic               data_valid_o;
  logic               done_res_o;
  logic [1:0]         status_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  host_req_t host_q[$];
  res_t      step_q[$];
  seq_t      card_seq;
  seq_t      plan_seq;
  int        issued;
  int        mismatches;
  int        stuck;
  int        send_gap;
  int        stall_left;
  int        calm_left;
  bit        calm;
  host_req_t nxt;
  res_t      want;
  res_t      got;

  sd_spi_reset_and_block_read_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic seq_t seq_reset();
    seq_t s;
    s           = '0;
    s.ph        = PH_IDLE;
    s.len       = 10'(BLOCK_BYTES);
    s.cmd       = CM_RESET0;
    s.idle_cs   = 1'b1;
    s.try_limit = TRY_LIMIT_RESET;
    return s;
  endfunction

  function automatic void open_cmd(inout seq_t s, input cmd_e c);
    s.cmd   = c;
    s.ph    = PH_PRE;
    s.cnt   = '0;
    s.polls = '0;
  endfunction

  function automatic logic [CNT_W-1:0] block_len(input seq_t s);
    return (s.mode == ACT_BYTE_READ) ? s.len : 10'(BLOCK_BYTES);
  endfunction

  function automatic void end_op(inout seq_t s, inout res_t r, input logic [1:0] code);
    s.ph          = PH_IDLE;
    s.idle_cs     = 1'b0;
    r.tx_byte     = 8'h00;
    r.chip_select = 1'b0;
    r.transfer    = 1'b0;
    r.done_res    = 1'b1;
    r.status      = code;
  endfunction

  // next byte exchange for the current phase and command
  function automatic void req_exchange(input seq_t s, inout res_t r);
    logic [7:0]  num;
    logic [31:0] arg;
    r.tx_byte     = FILL_BYTE;
    r.chip_select = 1'b0;
    r.transfer    = 1'b1;
    if (s.ph == PH_WAKE || s.ph == PH_PRE) begin
      r.chip_select = 1'b1;
    end else if (s.ph == PH_BODY) begin
      case (s.cmd)
        CM_RESET0: begin
          num = CMD_NUM_0;
          arg = '0;
        end
        CM_LEN_FINAL: begin
          num = CMD_NUM_16;
          arg = 32'(BLOCK_BYTES);
        end
        CM_LEN_SET: begin
          num = CMD_NUM_16;
          arg = 32'(s.len);
        end
        default: begin
          num = CMD_NUM_17;
          arg = (s.mode == ACT_SECT_READ) ? s.addr * 32'(BLOCK_BYTES) : s.addr;
        end
      endcase
      if (s.cnt == 0) r.tx_byte = CMD_START | num;
      else if (s.cnt <= 4) r.tx_byte = 8'(arg >> (8 * (4 - s.cnt)));
      else r.tx_byte = (s.cmd == CM_RESET0) ? CMD0_CRC : FILL_BYTE;
    end
  endfunction

  // end of reply polling; returns 1 when the operation is over
  function automatic bit close_cmd(inout seq_t s, inout res_t r, input bit hit);
    case (s.cmd)
      CM_RESET0: begin
        if (s.tries != 8'hff) s.tries = s.tries + 1'b1;
        if (hit) begin
          s.rst_fail = 1'b0;
          s.ph       = PH_TRAIL;
        end else if (s.tries >= s.try_limit) begin
          s.rst_fail = 1'b1;
          s.ph       = PH_TRAIL;
        end else begin
          open_cmd(s, CM_RESET0);
        end
      end
      CM_LEN_FINAL: begin
        end_op(s, r, ST_OK);
        return 1'b1;
      end
      CM_LEN_SET: begin
        s.tries = '0;
        open_cmd(s, CM_READ);
      end
      default: begin
        if (s.tries != 8'hff) s.tries = s.tries + 1'b1;
        if (hit) begin
          s.ph = PH_TOKEN;
        end else if (s.tries >= s.try_limit) begin
          end_op(s, r, ST_READ_FAIL);
          return 1'b1;
        end else begin
          open_cmd(s, CM_READ);
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic res_t sequencer_step(inout seq_t s, input logic [1:0] act,
                                          input logic [31:0] adr, input logic [9:0] len,
                                          input logic [7:0] rx);
    res_t       r;
    bit         ended;
    logic [7:0] reply;
    r     = '0;
    ended = 1'b0;
    if (act == ACT_RESET) begin
      s.mode     = ACT_RESET;
      s.rst_fail = 1'b0;
      s.tries    = '0;
      s.ph       = PH_WAKE;
      s.cnt      = '0;
      req_exchange(s, r);
      return r;
    end
    if (act == ACT_SECT_READ || act == ACT_BYTE_READ) begin
      s.mode  = act;
      s.addr  = adr;
      s.tries = '0;
      if (act == ACT_BYTE_READ) begin
        s.len = len;
        open_cmd(s, CM_LEN_SET);
      end else begin
        open_cmd(s, CM_READ);
      end
      req_exchange(s, r);
      return r;
    end
    case (s.ph)
      PH_IDLE: begin
        r.chip_select = s.idle_cs;
        return r;
      end
      PH_WAKE: begin
        s.cnt = s.cnt + 1'b1;
        if (s.cnt >= IDLE_BYTES) begin
          s.tries = '0;
          open_cmd(s, CM_RESET0);
        end
      end
      PH_PRE: begin
        s.cnt = s.cnt + 1'b1;
        if (s.cnt >= PRE_BYTES) begin
          s.ph  = PH_BODY;
          s.cnt = '0;
        end
      end
      PH_BODY: begin
        s.cnt = s.cnt + 1'b1;
        if (s.cnt >= BODY_BYTES) begin
          s.ph    = PH_POLL;
          s.polls = '0;
        end
      end
      PH_POLL: begin
        reply = (s.cmd == CM_RESET0) ? R1_IDLE : R1_READY;
        if (s.polls != 8'hff) s.polls = s.polls + 1'b1;
        if (rx == reply) ended = close_cmd(s, r, 1'b1);
        else if (s.polls >= s.try_limit) ended = close_cmd(s, r, 1'b0);
      end
      PH_TOKEN: begin
        if (rx == DATA_TOKEN) begin
          s.cnt = '0;
          s.ph  = (block_len(s) == 0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        r.data_byte  = rx;
        r.data_valid = 1'b1;
        s.cnt        = s.cnt + 1'b1;
        if (s.cnt >= block_len(s)) begin
          s.ph  = PH_CRC;
          s.cnt = '0;
        end
      end
      PH_CRC: begin
        s.cnt = s.cnt + 1'b1;
        if (s.cnt >= CRC_BYTES) s.ph = PH_TRAIL;
      end
      default: begin
        if (s.mode == ACT_RESET) begin
          if (s.rst_fail) begin
            end_op(s, r, ST_RESET_FAIL);
            ended = 1'b1;
          end else begin
            open_cmd(s, CM_LEN_FINAL);
          end
        end else if (s.mode == ACT_BYTE_READ) begin
          open_cmd(s, CM_LEN_FINAL);
        end else begin
          end_op(s, r, ST_OK);
          ended = 1'b1;
        end
      end
    endcase
    if (!ended) req_exchange(s, r);
    return r;
  endfunction

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // what a card might answer, given where the sequencer stands
  function automatic logic [7:0] card_reply(input seq_t s, input int hit_pct);
    if (s.ph == PH_POLL && $urandom_range(0, 99) < hit_pct)
      return (s.cmd == CM_RESET0) ? R1_IDLE : R1_READY;
    if (s.ph == PH_TOKEN && $urandom_range(0, 99) < 40) return DATA_TOKEN;
    if ($urandom_range(0, 3) == 0) return FILL_BYTE;
    return 8'($urandom);
  endfunction

  function automatic void push(input logic [1:0] act, input logic [31:0] adr,
                               input logic [9:0] len, input logic [7:0] rx);
    host_q.push_back('{act, adr, len, rx});
    void'(sequencer_step(plan_seq, act, adr, len, rx));
    issued++;
  endfunction

  function automatic void run_session(input logic [1:0] act, input int hit_pct, input int cap);
    int         steps;
    int         roll;
    logic [9:0] len;
    steps = 0;
    roll  = $urandom_range(0, 99);
    if (roll < 15) len = '0;
    else if (roll < 85) len = 10'($urandom_range(1, 16));
    else len = 10'($urandom_range(17, 64));
    push(act, $urandom, len, 8'($urandom));
    while (plan_seq.ph != PH_IDLE && steps < cap) begin
      push(ACT_RX, $urandom, 10'($urandom_range(1, 512)), card_reply(plan_seq, hit_pct));
      steps++;
    end
  endfunction

  task automatic gen_phase(input int quota, input int hit_pct, input bit with_sector);
    int first;
    int roll;
    int cap;
    @(negedge clk_i);
    first = issued;
    if (with_sector) run_session(ACT_SECT_READ, hit_pct, 100000);
    while (issued - first < quota) begin
      roll = $urandom_range(0, 99);
      cap  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : 100000;
      if (roll < 8) push(ACT_RX, $urandom, 10'($urandom_range(1, 512)), 8'($urandom));
      else if (roll < 35) run_session(ACT_RESET, hit_pct, cap);
      else run_session(ACT_BYTE_READ, hit_pct, cap);
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (host_q.size() != 0 || in_valid_i || step_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_TRY_LIMIT, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input logic [7:0] lim);
    logic [31:0] rd;
    drain();
    reg_access(1'b1, 32'(lim), rd);
    reg_access(1'b0, '0, rd);
    if (rd !== 32'(lim))
      flag($sformatf("try_limit readback mismatch: want %h got %h", 32'(lim), rd));
    card_seq.try_limit = lim;
    plan_seq.try_limit = lim;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        step_q.push_back(sequencer_step(card_seq, action_i, address_i, length_i, rx_byte_i));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (host_q.size() != 0) begin
          nxt = host_q.pop_front();
          action_i   <= nxt.action;
          address_i  <= nxt.address;
          length_i   <= nxt.length;
          rx_byte_i  <= nxt.rx;
          in_valid_i <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {tx_byte_o, chip_select_o, transfer_o, data_byte_o, data_valid_o, done_res_o,
               status_o};
        if (step_q.size() == 0) begin
          flag($sformatf("unexpected beat: tx %h cs %b xfer %b data %h dv %b done %b st %0d",
                         got.tx_byte, got.chip_select, got.transfer, got.data_byte,
                         got.data_valid, got.done_res, got.status));
        end else begin
          want = step_q.pop_front();
          if (got.tx_byte !== want.tx_byte || got.chip_select !== want.chip_select ||
              got.transfer !== want.transfer || got.data_byte !== want.data_byte ||
              got.data_valid !== want.data_valid || got.done_res !== want.done_res ||
              got.status !== want.status)
            flag($sformatf({"beat mismatch: want tx %h cs %b xfer %b data %h dv %b done %b ",
                            "st %0d, got tx %h cs %b xfer %b data %h dv %b done %b st %0d"},
                           want.tx_byte, want.chip_select, want.transfer, want.data_byte,
                           want.data_valid, want.done_res, want.status,
                           got.tx_byte, got.chip_select, got.transfer, got.data_byte,
                           got.data_valid, got.done_res, got.status));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // stretches without idling on either side
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) stuck <= 0;
    else stuck <= stuck + 1;
  end

  initial begin
    wait (stuck >= STUCK_LIMIT);
    $display("** sd_spi_reset_and_block_read_core: FAILED **");
    $finish;
  end

  initial begin
    logic [31:0] rd;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ACT_RX;
    address_i   = '0;
    length_i    = '0;
    rx_byte_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    stuck       = 0;
    issued      = 0;
    mismatches  = 0;
    card_seq    = seq_reset();
    plan_seq    = seq_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_access(1'b0, '0, rd);
    if (rd !== 32'(TRY_LIMIT_RESET))
      flag($sformatf("try_limit reset mismatch: want %h got %h", 32'(TRY_LIMIT_RESET), rd));

    @(negedge clk_i);
    // idle after reset keeps the select line high
    push(ACT_RX, 32'h0, 10'd1, 8'hff);
    // sector number wraps when scaled to a byte address
    push(ACT_SECT_READ, 32'hffff_ffff, 10'd512, 8'h00);
    for (int i = 0; i < 9; i++) push(ACT_RX, 32'h0, 10'd1, i[0] ? 8'h00 : 8'hff);
    // restarts abort whatever is in progress
    push(ACT_BYTE_READ, 32'h0, 10'd512, 8'hff);
    for (int i = 0; i < 3; i++) push(ACT_RX, 32'hffff_ffff, 10'd512, 8'h00);
    push(ACT_BYTE_READ, 32'hffff_ffff, 10'd0, 8'h00);
    for (int i = 0; i < 2; i++) push(ACT_RX, 32'h0, 10'd1, 8'hff);
    push(ACT_RESET, 32'hffff_ffff, 10'd512, 8'hff);
    for (int i = 0; i < 3; i++) push(ACT_RX, 32'h0, 10'd1, 8'h01);
    push(ACT_SECT_READ, 32'h0, 10'd1, 8'h00);

    gen_phase(260, 60, 1'b0);
    set_limit(8'd1);
    gen_phase(260, 35, 1'b0);
    set_limit(8'd255);
    gen_phase(260, 60, 1'b1);
    set_limit(8'd0);
    gen_phase(260, 40, 1'b0);
    set_limit(8'd3);
    gen_phase(260, 35, 1'b0);
    set_limit(8'($urandom_range(2, 254)));
    gen_phase(260, 50, 1'b0);
    drain();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && step_q.size() == 0 && host_q.size() == 0)
      $display("** sd_spi_reset_and_block_read_core: PASSED **");
    else
      $display("** sd_spi_reset_and_block_read_core: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sdsr_pkg.sv
rtl/sd_spi_reset_and_block_read_core.sv
tb/sd_spi_reset_and_block_read_core_tb.sv
